// File: hw/rtl/module_status_frame_parser_unit_macros.svh
// Assertion macros for the module status frame parser.
// Included by the RTL files that carry concurrent checks; no other dependencies.
`ifndef MODULE_STATUS_FRAME_PARSER_UNIT_MACROS_SVH
`define MODULE_STATUS_FRAME_PARSER_UNIT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define MSFP_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("msfp check failed");

// Next-cycle implication, disabled during reset.
`define MSFP_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("msfp check failed");

`endif

// File: hw/rtl/msfp_pkg.sv
// Shared types and constants of the module status frame parser.
// No dependencies; used by the decoder, echo stage and top level.
package msfp_pkg;

  localparam int unsigned FRAME_LEN  = 17;
  localparam int unsigned IDX_W      = 5;
  localparam logic [7:0]  START_BYTE = 8'hAA;

  localparam logic [1:0] CALL_NONE     = 2'd0;
  localparam logic [1:0] CALL_INCOMING = 2'd1;
  localparam logic [1:0] CALL_OUTGOING = 2'd2;

  // Decoded transaction handed from the decoder to the echo stage.
  typedef struct packed {
    logic [7:0] rx_byte;
    logic       start;
    logic       paired;
    logic [1:0] call_status;
    logic       music_playing;
  } rec_t;

endpackage

// File: hw/rtl/msfp_if.sv
// Valid/ready channel interfaces of the module status frame parser.
// Input byte channel and echo character channel; no package dependency.
interface msfp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface msfp_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] echo_char;
  logic       last_char;
  logic       paired;
  logic [1:0] call_status;
  logic       music_playing;

  modport source (output valid, output echo_char, output last_char, output paired,
                  output call_status, output music_playing, input ready);
  modport sink   (input valid, input echo_char, input last_char, input paired,
                  input call_status, input music_playing, output ready);
endinterface

// File: hw/rtl/module_status_frame_parser_unit.sv
// Module status frame parser, top level.
// Depends on msfp_pkg, msfp_if.sv, msfp_decoder and msfp_echo.
//
// Usage:
//   link carries received bytes from the wireless module (rx_byte). A 0xAA
//   byte opens a 17-byte frame that is captured into the frame store; after
//   every byte the store is decoded and the paired, call and music status
//   updated.
//   echo carries the byte back as ASCII: CR LF before a 0xAA, then two upper
//   case hex digits and a space (last_char set on the space). Every character
//   of a byte carries the status after that byte.
// Timing:
//   A byte is decoded in the cycle it is accepted and registered; the echo
//   stage loads it into its own register once it is free, and its first
//   character is offered from there. The echo serializer emits one character
//   per cycle while echo is ready, so a byte occupies it for three characters,
//   or five for 0xAA. One decoded byte waits in a register while the previous
//   one is still being echoed, so link takes one more byte during that time.
// Reset:
//   Synchronous, active high. The frame store returns to all 0xFF, capture,
//   index and status flags clear, nothing is pending.
// Backpressure:
//   While echo is stalled the current character holds; once the holding
//   register is full, link.ready drops until the echo moves on.
module module_status_frame_parser_unit (
  input  logic        clk,
  input  logic        rst,
  msfp_in_if.sink     link,
  msfp_out_if.source  echo
);

  msfp_pkg::rec_t rec;
  logic           rec_valid;
  logic           rec_take;

  msfp_decoder u_decoder (
    .clk       (clk),
    .rst       (rst),
    .link      (link),
    .rec       (rec),
    .rec_valid (rec_valid),
    .rec_take  (rec_take)
  );

  msfp_echo u_echo (
    .clk       (clk),
    .rst       (rst),
    .rec       (rec),
    .rec_valid (rec_valid),
    .rec_take  (rec_take),
    .echo      (echo)
  );

endmodule

// File: hw/rtl/msfp_decoder.sv
// Frame capture, frame store and status decode; one byte per transaction.
// Depends on msfp_pkg, msfp_if.sv and the assertion macro header.
`include "module_status_frame_parser_unit_macros.svh"

module msfp_decoder (
  input  logic            clk,
  input  logic            rst,
  msfp_in_if.sink         link,
  output msfp_pkg::rec_t  rec,
  output logic            rec_valid,
  input  logic            rec_take
);

  localparam logic [7:0] KEY_PAIR   = 8'h01;
  localparam logic [7:0] KEY_CALL   = 8'h02;
  localparam logic [7:0] PAIR_ON    = 8'h06;
  localparam logic [7:0] PAIR_OFF   = 8'h08;
  localparam logic [7:0] CALL_B_NONE = 8'h00;
  localparam logic [7:0] CALL_B_IN   = 8'h02;
  localparam logic [7:0] CALL_B_OUT  = 8'h04;
  localparam logic [7:0] MUSIC_K2   = 8'h0E;
  localparam logic [7:0] MUSIC_K3   = 8'h1A;
  localparam logic [7:0] MUSIC_K5   = 8'h0F;
  localparam logic [7:0] MUSIC_OFF  = 8'h02;
  localparam logic [7:0] MUSIC_ON   = 8'h01;
  localparam logic [msfp_pkg::IDX_W-1:0] LEN = msfp_pkg::IDX_W'(msfp_pkg::FRAME_LEN);

  logic [7:0]                  store [msfp_pkg::FRAME_LEN];
  logic                        capturing;
  logic [msfp_pkg::IDX_W-1:0]  frame_index;
  logic                        paired_flag;
  logic [1:0]                  call_state;
  logic                        music_flag;

  logic                        fire;
  logic                        is_start;
  logic                        cap_eff;
  logic [msfp_pkg::IDX_W-1:0]  idx_eff;
  logic [msfp_pkg::IDX_W-1:0]  idx_inc;
  logic                        wr;
  logic [7:0]                  s2, s3, s4, s5, s16;
  logic                        paired_next;
  logic [1:0]                  call_next;
  logic                        music_next;
  logic                        capturing_next;
  logic [msfp_pkg::IDX_W-1:0]  frame_index_next;

  assign link.ready = !rec_valid || rec_take;
  assign fire       = link.valid && link.ready;

  assign is_start = (link.rx_byte == msfp_pkg::START_BYTE);
  assign cap_eff  = is_start || capturing;
  assign idx_eff  = is_start ? '0 : frame_index;
  assign idx_inc  = idx_eff + 1'b1;
  assign wr       = cap_eff && (idx_eff < LEN);

  // Store contents after this byte is written.
  assign s2  = (wr && idx_eff == msfp_pkg::IDX_W'(2))  ? link.rx_byte : store[2];
  assign s3  = (wr && idx_eff == msfp_pkg::IDX_W'(3))  ? link.rx_byte : store[3];
  assign s4  = (wr && idx_eff == msfp_pkg::IDX_W'(4))  ? link.rx_byte : store[4];
  assign s5  = (wr && idx_eff == msfp_pkg::IDX_W'(5))  ? link.rx_byte : store[5];
  assign s16 = (wr && idx_eff == msfp_pkg::IDX_W'(16)) ? link.rx_byte : store[16];

  always_comb begin
    paired_next = paired_flag;
    call_next   = call_state;
    music_next  = music_flag;
    if (s3 == KEY_PAIR) begin
      if (s4 == PAIR_ON) begin
        paired_next = 1'b1;
      end else if (s4 == PAIR_OFF) begin
        paired_next = 1'b0;
      end
    end else if (s3 == KEY_CALL) begin
      if (s5 == CALL_B_NONE) begin
        call_next = msfp_pkg::CALL_NONE;
      end else if (s5 == CALL_B_IN) begin
        call_next = msfp_pkg::CALL_INCOMING;
      end else if (s5 == CALL_B_OUT) begin
        call_next = msfp_pkg::CALL_OUTGOING;
      end
    end
    if (s2 == MUSIC_K2 && s3 == MUSIC_K3 && s5 == MUSIC_K5) begin
      if (s16 == MUSIC_OFF) begin
        music_next = 1'b0;
      end else if (s16 == MUSIC_ON) begin
        music_next = 1'b1;
      end
    end
  end

  always_comb begin
    if (wr && idx_inc < LEN) begin
      capturing_next   = 1'b1;
      frame_index_next = idx_inc;
    end else if (wr) begin
      capturing_next   = 1'b0;
      frame_index_next = '0;
    end else begin
      capturing_next   = cap_eff;
      frame_index_next = idx_eff;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < msfp_pkg::FRAME_LEN; k++) begin
        store[k] <= 8'hFF;
      end
      capturing   <= 1'b0;
      frame_index <= '0;
      paired_flag <= 1'b0;
      call_state  <= msfp_pkg::CALL_NONE;
      music_flag  <= 1'b0;
      rec_valid   <= 1'b0;
    end else if (fire) begin
      if (wr) begin
        store[idx_eff] <= link.rx_byte;
      end
      capturing   <= capturing_next;
      frame_index <= frame_index_next;
      paired_flag <= paired_next;
      call_state  <= call_next;
      music_flag  <= music_next;
      rec_valid   <= 1'b1;
    end else if (rec_take) begin
      rec_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      rec.rx_byte       <= link.rx_byte;
      rec.start         <= is_start;
      rec.paired        <= paired_next;
      rec.call_status   <= call_next;
      rec.music_playing <= music_next;
    end
  end

  `MSFP_ASSERT_NOW(a_idx_range, clk, rst, 1'b1, frame_index < LEN)
  `MSFP_ASSERT_NOW(a_idle_idx_zero, clk, rst, !capturing, frame_index == '0)
  `MSFP_ASSERT_NEXT(a_start_opens, clk, rst, fire && is_start,
                    capturing && frame_index == msfp_pkg::IDX_W'(1) && rec.start)

endmodule

// File: hw/rtl/msfp_echo.sv
// Echo serializer: turns one decoded transaction into 3 or 5 output characters.
// Depends on msfp_pkg, msfp_if.sv and the assertion macro header.
`include "module_status_frame_parser_unit_macros.svh"

module msfp_echo (
  input  logic            clk,
  input  logic            rst,
  input  msfp_pkg::rec_t  rec,
  input  logic            rec_valid,
  output logic            rec_take,
  msfp_out_if.source      echo
);

  typedef enum logic [2:0] {
    POS_CR,
    POS_LF,
    POS_HI,
    POS_LO,
    POS_SP
  } pos_t;

  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_A_LESS_TEN = 8'h37;

  msfp_pkg::rec_t cur;
  logic           busy;
  pos_t           pos;
  logic           out_fire;
  logic           done;

  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    logic [7:0] w;
    w = {4'h0, nib};
    return (nib < 4'd10) ? (CH_ZERO + w) : (CH_A_LESS_TEN + w);
  endfunction

  assign out_fire = echo.valid && echo.ready;
  assign done     = out_fire && (pos == POS_SP);
  assign rec_take = rec_valid && (!busy || done);

  always_comb begin
    case (pos)
      POS_CR:  echo.echo_char = CH_CR;
      POS_LF:  echo.echo_char = CH_LF;
      POS_HI:  echo.echo_char = hex_char(cur.rx_byte[7:4]);
      POS_LO:  echo.echo_char = hex_char(cur.rx_byte[3:0]);
      default: echo.echo_char = CH_SPACE;
    endcase
  end

  assign echo.valid         = busy;
  assign echo.last_char     = (pos == POS_SP);
  assign echo.paired        = cur.paired;
  assign echo.call_status   = cur.call_status;
  assign echo.music_playing = cur.music_playing;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      pos  <= POS_HI;
    end else if (rec_take) begin
      busy <= 1'b1;
      pos  <= rec.start ? POS_CR : POS_HI;
    end else if (done) begin
      busy <= 1'b0;
    end else if (out_fire) begin
      pos <= pos_t'(pos + 3'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (rec_take) begin
      cur <= rec;
    end
  end

  `MSFP_ASSERT_NOW(a_crlf_only_start, clk, rst, busy && !cur.start,
                   pos == POS_HI || pos == POS_LO || pos == POS_SP)
  `MSFP_ASSERT_NEXT(a_drain_idle, clk, rst, done && !rec_valid, !busy)
  `MSFP_ASSERT_NEXT(a_step, clk, rst, out_fire && pos != POS_SP,
                    busy && pos == pos_t'($past(pos) + 3'd1))

endmodule
